>>> rtl/ard_pkg.sv
// ----------------------------------------------------------------------------
// ard_pkg
// Shared types and constants of the arithmetic range decoder.
// ----------------------------------------------------------------------------
package ard_pkg;

    localparam int PREC      = 59;
    localparam int FIFO_BITS = 256;
    localparam int FREQ_BITS = 32;
    localparam int PTR_W     = $clog2(FIFO_BITS);
    localparam int CNT_W     = PTR_W + 1;
    localparam int SH_W      = $clog2(PREC + 1);
    // one extra dividend bit so the full interval width 2^PREC fits
    localparam int DIV_W     = PREC + 1;
    localparam int QB_W      = $clog2(DIV_W + 1);

    localparam logic [PREC-1:0] VAL_MASK = {PREC{1'b1}};
    localparam logic [PREC-1:0] HALF_PT  = {1'b1, {(PREC-1){1'b0}}};
    localparam logic [PREC-1:0] QTR1_PT  = {2'b01, {(PREC-2){1'b0}}};
    localparam logic [PREC-1:0] QTR3_PT  = {2'b11, {(PREC-2){1'b0}}};

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_START  = 2'd1,
        CMD_DECODE = 2'd2,
        CMD_UPDATE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_STARVED = 2'd1,
        ST_ZERO    = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_PUSH, S_START, S_DIV1, S_DIV1_END, S_DIV2, S_DIV2_END,
        S_MUL, S_MUL_END, S_REN1, S_REN2, S_DONE
    } t_state;

    // divider control to the shared divide unit
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [PREC-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

endpackage

>>> rtl/arithmetic_range_decoder_top.sv
// Results are set by the bit-serial divider, the shift-add multiplier and one
// renormalising shift per cycle; a push into a full fifo, a zero total and a
// zero step go straight to the result.
// Throughput: one request at a time; next request accepted once result is taken.
// Reset: synchronous active low; interval full range, fifo empty, step zero.
// ----------------------------------------------------------------------------
// arithmetic_range_decoder_top
// Arithmetic range decoder with a bit fifo, shared divider and sequencer.
// ----------------------------------------------------------------------------
module arithmetic_range_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_data_byte,
    input  logic [31:0] i_freq_total,
    input  logic [31:0] i_range_start,
    input  logic [31:0] i_range_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_target_count,
    output logic [8:0]  o_bits_held,
    output logic [1:0]  o_status
);
    import ard_pkg::*;

    t_state           r_state, n_state;
    logic [PREC-1:0]  r_low, n_low, r_high, n_high, r_code, n_code, r_step, n_step;
    logic [PREC-1:0]  r_acc_a, n_acc_a, r_acc_b, n_acc_b;
    logic [FREQ_BITS-1:0] r_ms, n_ms, r_me, n_me;
    logic [FREQ_BITS-1:0] r_total, n_total;
    logic [7:0]       r_byte, n_byte;
    logic [SH_W-1:0]  r_cnt, n_cnt;
    t_cmd             r_cmd, n_cmd;
    logic             r_starved, n_starved;
    logic [31:0]      r_target, n_target;
    t_status          r_status, n_status;
    logic             r_ovalid, n_ovalid;
    logic [PREC-1:0]  r_mcand, n_mcand;

    t_div_req         w_div_req;
    t_div_rsp         w_div_rsp;
    logic             w_wr, w_wr_bit, w_rd, w_fbit;
    logic [CNT_W-1:0] w_count;
    logic             w_pulled;
    logic [PREC-1:0]  w_base;
    logic [DIV_W-1:0] w_width;
    logic             w_shift;

    ard_divider u_div (.i_clk, .i_rst_n, .i_req(w_div_req), .o_rsp(w_div_rsp));

    ard_bit_fifo u_fifo (
        .i_clk, .i_rst_n, .i_wr(w_wr), .i_wr_bit(w_wr_bit), .i_rd(w_rd),
        .o_rd_bit(w_fbit), .o_count(w_count)
    );

    // a waiting result holds off the next request until it is taken
    assign o_ready        = (r_state == S_IDLE) && (!r_ovalid || i_ready);
    assign o_valid        = r_ovalid;
    assign o_target_count = r_target;
    assign o_bits_held    = 9'(w_count);
    assign o_status       = r_status;

    // sequencer
    always_comb begin
        n_state = r_state; n_low = r_low; n_high = r_high; n_code = r_code;
        n_step = r_step; n_acc_a = r_acc_a; n_acc_b = r_acc_b; n_ms = r_ms;
        n_me = r_me; n_total = r_total; n_byte = r_byte; n_cnt = r_cnt;
        n_cmd = r_cmd; n_starved = r_starved; n_target = r_target;
        n_status = r_status; n_ovalid = r_ovalid; n_mcand = r_mcand;
        w_div_req = '0; w_wr = 1'b0; w_wr_bit = r_byte[7]; w_rd = 1'b0;
        w_pulled = 1'b0; w_base = '0; w_shift = 1'b0;
        w_width = (r_high >= r_low) ? ({1'b0, r_high} - {1'b0, r_low} + 1'b1) : '0;
        if (w_count != '0) w_pulled = w_fbit;
        unique case (r_state)
            S_IDLE: begin
                if (r_ovalid && i_ready) n_ovalid = 1'b0;
                if (i_valid && o_ready) begin
                    n_cmd = t_cmd'(i_command); n_byte = i_data_byte;
                    n_total = i_freq_total; n_ms = i_range_start; n_me = i_range_end;
                    n_starved = 1'b0; n_target = '0; n_status = ST_OK;
                    n_ovalid = 1'b0;
                    unique case (t_cmd'(i_command))
                        CMD_PUSH: begin
                            n_cnt = SH_W'(8);
                            if (w_count + CNT_W'(8) > CNT_W'(FIFO_BITS)) begin
                                n_status = ST_FULL; n_state = S_DONE;
                            end else n_state = S_PUSH;
                        end
                        CMD_START: begin
                            n_low = '0; n_high = VAL_MASK; n_step = '0; n_code = '0;
                            n_cnt = SH_W'(PREC); n_state = S_START;
                        end
                        CMD_DECODE: n_state = S_DIV1;
                        CMD_UPDATE: begin
                            n_acc_a = '0; n_acc_b = '0; n_mcand = r_step;
                            n_cnt = SH_W'(FREQ_BITS); n_state = S_MUL;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_PUSH: begin
                w_wr = 1'b1; n_byte = {r_byte[6:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == SH_W'(1)) n_state = S_DONE;
            end
            S_START: begin
                if (w_count == '0) n_starved = 1'b1; else w_rd = 1'b1;
                n_code = {r_code[PREC-2:0], w_pulled};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == SH_W'(1)) n_state = S_DONE;
            end
            S_DIV1: begin
                if (r_total == '0) begin
                    n_status = ST_ZERO; n_state = S_DONE;
                end else begin
                    w_div_req.start = 1'b1; w_div_req.dividend = w_width;
                    w_div_req.divisor = PREC'(r_total); n_state = S_DIV1_END;
                end
            end
            S_DIV1_END: begin
                if (!w_div_rsp.busy) begin
                    // step keeps the low PREC bits of the quotient
                    n_step = w_div_rsp.quot[PREC-1:0];
                    if (w_div_rsp.quot[PREC-1:0] == '0) begin
                        n_status = ST_ZERO; n_state = S_DONE;
                    end else begin
                        w_div_req.start = 1'b1;
                        w_div_req.dividend = {1'b0, r_code - r_low};
                        w_div_req.divisor = w_div_rsp.quot[PREC-1:0];
                        n_state = S_DIV2_END;
                    end
                end
            end
            S_DIV2: n_state = S_DIV2_END;
            S_DIV2_END: begin
                if (!w_div_rsp.busy) begin
                    n_target = (|w_div_rsp.quot[DIV_W-1:FREQ_BITS]) ? '1
                             : w_div_rsp.quot[FREQ_BITS-1:0];
                    n_state = S_DONE;
                end
            end
            S_MUL: begin
                // shift-add, one multiplier bit of each factor per cycle
                if (r_me[0]) n_acc_b = r_acc_b + r_mcand;
                if (r_ms[0]) n_acc_a = r_acc_a + r_mcand;
                n_me = r_me >> 1; n_ms = r_ms >> 1;
                n_mcand = {r_mcand[PREC-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == SH_W'(1)) n_state = S_MUL_END;
            end
            S_MUL_END: begin
                n_high = r_low + r_acc_b - 1'b1;
                n_low  = r_low + r_acc_a;
                n_cnt = SH_W'(PREC); n_state = S_REN1;
            end
            S_REN1: begin
                if (r_high < HALF_PT) begin
                    w_shift = 1'b1; w_base = '0;
                end else if (r_low >= HALF_PT) begin
                    w_shift = 1'b1; w_base = HALF_PT;
                end
                if (!w_shift || r_cnt == SH_W'(1)) begin
                    n_state = S_REN2;
                end
                n_cnt = (!w_shift || r_cnt == SH_W'(1)) ? SH_W'(PREC) : r_cnt - 1'b1;
            end
            S_REN2: begin
                if (r_low >= QTR1_PT && r_high < QTR3_PT) begin
                    w_shift = 1'b1; w_base = QTR1_PT;
                end
                if (!w_shift || r_cnt == SH_W'(1)) n_state = S_DONE;
                n_cnt = r_cnt - 1'b1;
            end
            S_DONE: begin
                if (r_starved && n_status == ST_OK) n_status = ST_STARVED;
                n_ovalid = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        // shared renormalising shifter
        if (w_shift) begin
            if (w_count == '0) n_starved = 1'b1; else w_rd = 1'b1;
            n_low  = PREC'((r_low - w_base) << 1);
            n_high = PREC'(((r_high - w_base) << 1) | 1'b1);
            n_code = PREC'(((r_code - w_base) << 1) | PREC'(w_pulled));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ovalid <= 1'b0;
            r_low <= '0; r_high <= VAL_MASK; r_code <= '0; r_step <= '0;
        end else begin
            r_state <= n_state; r_ovalid <= n_ovalid;
            r_low <= n_low; r_high <= n_high; r_code <= n_code; r_step <= n_step;
        end
        r_acc_a <= n_acc_a; r_acc_b <= n_acc_b; r_ms <= n_ms; r_me <= n_me;
        r_total <= n_total; r_byte <= n_byte; r_cnt <= n_cnt; r_cmd <= n_cmd;
        r_starved <= n_starved; r_target <= n_target; r_status <= n_status;
        r_mcand <= n_mcand;
    end

    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_state == S_IDLE)) else $error("result shown while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |=> (r_ovalid && $stable(r_target)))
        else $error("result changed before taken");
    a_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_cmd != CMD_DECODE) |-> (r_target == '0))
        else $error("target set for non-decode");

endmodule

>>> rtl/ard_divider.sv
// ----------------------------------------------------------------------------
// ard_divider
// Restoring divider, one quotient bit per cycle, shared by both divides.
// ----------------------------------------------------------------------------
module ard_divider (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ard_pkg::t_div_req i_req,
    output ard_pkg::t_div_rsp o_rsp
);
    import ard_pkg::*;

    logic [QB_W-1:0]  r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic [DIV_W-1:0] r_q, n_q;
    logic [PREC:0]    r_rem, n_rem;
    logic [PREC-1:0]  r_dvs, n_dvs;
    logic [PREC:0]    w_trial;

    // one subtract and compare per cycle
    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        w_trial = {r_rem[PREC-1:0], r_q[DIV_W-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = QB_W'(DIV_W);
            n_q    = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_dvs}) begin
                n_rem = w_trial - {1'b0, r_dvs};
                n_q   = {r_q[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_q   = {r_q[DIV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == QB_W'(1)) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.quot = r_q;

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_cnt == '0)) else $error("divider count not zero when idle");
    a_busy_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == QB_W'(1) && !i_req.start) |=> !r_busy)
        else $error("divider overran");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy) else $error("divider did not start");

endmodule

>>> rtl/ard_bit_fifo.sv
// ----------------------------------------------------------------------------
// ard_bit_fifo
// Bit FIFO of compressed stream bits, up to one bit written and one read per cycle.
// ----------------------------------------------------------------------------
module ard_bit_fifo (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr,
    input  logic                     i_wr_bit,
    input  logic                     i_rd,
    output logic                     o_rd_bit,
    output logic [ard_pkg::CNT_W-1:0] o_count
);
    import ard_pkg::*;

    logic              r_mem [FIFO_BITS];
    logic [PTR_W-1:0]  r_wp, r_rp;
    logic [CNT_W-1:0]  r_count;
    logic              r_rd_bit;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_wr_bit;
    end

    // prefetched head bit, registered read
    always_ff @(posedge i_clk) begin
        r_rd_bit <= r_mem[i_rd ? PTR_W'(r_rp + 1'b1) : r_rp];
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) r_wp <= r_wp + 1'b1;
            if (i_rd) r_rp <= r_rp + 1'b1;
            r_count <= r_count + CNT_W'(i_wr) - CNT_W'(i_rd);
        end
    end

    assign o_rd_bit = r_rd_bit;
    assign o_count  = r_count;

    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> (r_count != '0)) else $error("bit fifo read when empty");
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> (r_count != CNT_W'(FIFO_BITS))) else $error("bit fifo overflow");
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_BITS)) else $error("bit fifo count out of range");

endmodule

>>> tb/tb_arithmetic_range_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arithmetic_range_decoder_top
// Drives push, start, decode and update requests into the arithmetic range
// decoder and checks every response against an in-bench model of the
// interval, code register and bit fifo.
// ----------------------------------------------------------------------------
module tb_arithmetic_range_decoder_top;
    import ard_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM       = 800;
    localparam int N_DIRECTED     = 22;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_command;
    logic [7:0]  i_data_byte;
    logic [31:0] i_freq_total;
    logic [31:0] i_range_start;
    logic [31:0] i_range_end;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_target_count;
    logic [8:0]  o_bits_held;
    logic [1:0]  o_status;

    typedef struct packed {
        logic [31:0] target;
        logic [8:0]  held;
        t_status     status;
    } t_resp;

    typedef struct {
        t_cmd        cmd;
        logic [7:0]  byte_in;
        logic [31:0] total;
        logic [31:0] rs;
        logic [31:0] re;
        bit          has_exp;
        t_resp       exp;
    } t_row;

    arithmetic_range_decoder_top u_dut (.*);

    // model state
    logic [PREC-1:0] m_low, m_high, m_code, m_step;
    logic            m_fifo [FIFO_BITS];
    int unsigned     m_count, m_rd, m_wr;
    bit              m_starved;

    t_resp       resp_q [$];
    t_row        table_rows [N_DIRECTED];
    int          errors;
    int          send_idle_pct, recv_stall_pct;
    bit          hold_off;
    int          idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic take_bit();
        logic b;
        if (m_count == 0) begin
            m_starved = 1'b1;
            return 1'b0;
        end
        b = m_fifo[m_rd];
        m_rd = (m_rd + 1) % FIFO_BITS;
        m_count--;
        return b;
    endfunction

    function automatic void renorm_shift(logic [PREC-1:0] base);
        logic b;
        b = take_bit();
        m_low  = (m_low - base) << 1;
        m_high = ((m_high - base) << 1) | 1'b1;
        m_code = ((m_code - base) << 1) | b;
    endfunction

    // predict one response and advance model state
    function automatic t_resp decode_predict(t_cmd cmd, logic [7:0] bt, logic [31:0] tot,
                                             logic [31:0] rs, logic [31:0] re);
        t_resp r;
        logic [PREC:0]   width;
        logic [PREC-1:0] q;
        logic [PREC-1:0] diff;
        r.target = '0;
        r.status = ST_OK;
        m_starved = 1'b0;
        case (cmd)
            CMD_PUSH: begin
                if (m_count + 8 > FIFO_BITS) r.status = ST_FULL;
                else begin
                    for (int i = 0; i < 8; i++) begin
                        m_fifo[m_wr] = bt[7-i];
                        m_wr = (m_wr + 1) % FIFO_BITS;
                        m_count++;
                    end
                end
            end
            CMD_START: begin
                m_low = '0;
                m_high = VAL_MASK;
                m_step = '0;
                m_code = '0;
                for (int i = 0; i < PREC; i++) m_code = (m_code << 1) | take_bit();
            end
            CMD_DECODE: begin
                if (tot == 0) r.status = ST_ZERO;
                else begin
                    width = '0;
                    if (m_high >= m_low) width = {1'b0, m_high} - {1'b0, m_low} + 1;
                    m_step = PREC'(width / tot);
                    if (m_step == 0) r.status = ST_ZERO;
                    else begin
                        diff = m_code - m_low;
                        q = diff / m_step;
                        r.target = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
                    end
                end
            end
            default: begin
                m_high = m_low + m_step * PREC'(re) - 1;
                m_low  = m_low + m_step * PREC'(rs);
                for (int n = 0; n < PREC; n++) begin
                    if (m_high < HALF_PT) renorm_shift('0);
                    else if (m_low >= HALF_PT) renorm_shift(HALF_PT);
                    else break;
                end
                for (int n = 0; n < PREC; n++) begin
                    if (m_low >= QTR1_PT && m_high < QTR3_PT) renorm_shift(QTR1_PT);
                    else break;
                end
            end
        endcase
        if (m_starved && r.status == ST_OK) r.status = ST_STARVED;
        r.held = 9'(m_count);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // send one request, holding valid until accepted
    task automatic send_request(t_cmd cmd, logic [7:0] bt, logic [31:0] tot,
                                logic [31:0] rs, logic [31:0] re);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        i_valid = 1'b1;
        i_command = cmd;
        i_data_byte = bt;
        i_freq_total = tot;
        i_range_start = rs;
        i_range_end = re;
        do @(posedge i_clk); while (!o_ready);
        resp_q.insert(resp_q.size(), decode_predict(cmd, bt, tot, rs, re));
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    function automatic t_row mk(t_cmd c, logic [7:0] b, logic [31:0] t, logic [31:0] s,
                                logic [31:0] e, bit h, logic [31:0] et, logic [8:0] eh,
                                t_status es);
        t_row r;
        r.cmd = c; r.byte_in = b; r.total = t; r.rs = s; r.re = e;
        r.has_exp = h; r.exp = '{et, eh, es};
        return r;
    endfunction

    // receiver ready and response checking
    always @(negedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_resp w;
        if (i_rst_n && o_valid && i_ready) begin
            if (resp_q.size() == 0) begin
                report_mismatch("unexpected response", 32'(o_status), 0);
            end else begin
                w = resp_q.pop_front();
                if (o_target_count !== w.target)
                    report_mismatch("target_count", o_target_count, w.target);
                if (o_bits_held !== w.held)
                    report_mismatch("bits_held", 32'(o_bits_held), 32'(w.held));
                if (o_status !== w.status)
                    report_mismatch("status", 32'(o_status), 32'(w.status));
            end
        end
    end

    // watchdog on cycles with no accepted request or response
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog timeout at %0t", $realtime);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_row     r;
        int       ph;
        int       k;
        int       unsigned tot, a, b;
        errors = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_command = CMD_PUSH;
        i_data_byte = '0;
        i_freq_total = '0;
        i_range_start = '0;
        i_range_end = '0;
        m_low = '0; m_high = VAL_MASK; m_code = '0; m_step = '0;
        m_count = 0; m_rd = 0; m_wr = 0;
        foreach (m_fifo[i]) m_fifo[i] = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table: extremes, empty fifo, zero totals
        table_rows[0]  = mk(CMD_DECODE, 8'h00, 32'd0, 0, 0, 1, 0, 0, ST_ZERO);
        table_rows[1]  = mk(CMD_START, 8'h00, 0, 0, 0, 1, 0, 0, ST_STARVED);
        table_rows[2]  = mk(CMD_UPDATE, 8'h00, 0, 0, 0, 0, 0, 0, ST_OK);
        table_rows[3]  = mk(CMD_PUSH, 8'hFF, 0, 0, 0, 1, 0, 9'd8, ST_OK);
        table_rows[4]  = mk(CMD_PUSH, 8'h00, 0, 0, 0, 1, 0, 9'd16, ST_OK);
        table_rows[5]  = mk(CMD_PUSH, 8'hA5, 0, 0, 0, 0, 0, 0, ST_OK);
        table_rows[6]  = mk(CMD_PUSH, 8'h5A, 0, 0, 0, 0, 0, 0, ST_OK);
        table_rows[7]  = mk(CMD_PUSH, 8'hC3, 0, 0, 0, 0, 0, 0, ST_OK);
        table_rows[8]  = mk(CMD_PUSH, 8'h3C, 0, 0, 0, 0, 0, 0, ST_OK);
        table_rows[9]  = mk(CMD_PUSH, 8'h81, 0, 0, 0, 0, 0, 0, ST_OK);
        table_rows[10] = mk(CMD_PUSH, 8'h7E, 0, 0, 0, 0, 0, 0, ST_OK);
        table_rows[11] = mk(CMD_START, 8'h00, 0, 0, 0, 0, 0, 0, ST_OK);
        table_rows[12] = mk(CMD_DECODE, 8'h00, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, ST_OK);
        table_rows[13] = mk(CMD_UPDATE, 8'h00, 0, 32'd0, 32'd1, 0, 0, 0, ST_OK);
        table_rows[14] = mk(CMD_DECODE, 8'h00, 32'd1, 0, 0, 0, 0, 0, ST_OK);
        table_rows[15] = mk(CMD_UPDATE, 8'h00, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0,
                            0, ST_OK);
        table_rows[16] = mk(CMD_DECODE, 8'h00, 32'd3, 0, 0, 0, 0, 0, ST_OK);
        table_rows[17] = mk(CMD_UPDATE, 8'h00, 0, 32'd2, 32'd1, 0, 0, 0, ST_OK);
        table_rows[18] = mk(CMD_DECODE, 8'h00, 32'd0, 0, 0, 0, 0, 0, ST_ZERO);
        table_rows[19] = mk(CMD_START, 8'h00, 0, 0, 0, 0, 0, 0, ST_OK);
        table_rows[20] = mk(CMD_DECODE, 8'h00, 32'd2, 0, 0, 0, 0, 0, ST_OK);
        table_rows[21] = mk(CMD_UPDATE, 8'h00, 0, 32'd1, 32'd2, 0, 0, 0, ST_OK);
        for (int i = 0; i < N_DIRECTED; i++) begin
            r = table_rows[i];
            send_request(r.cmd, r.byte_in, r.total, r.rs, r.re);
            if (r.has_exp) begin
                if (resp_q[$].target !== r.exp.target || resp_q[$].held !== r.exp.held ||
                    resp_q[$].status !== r.exp.status)
                    report_mismatch("directed row", i, 0);
            end
        end
        // fill fifo to full, then one dropped byte
        for (int i = 0; i < 33; i++) send_request(CMD_PUSH, 8'($urandom), 0, 0, 0);
        if (resp_q[$].status !== ST_FULL) report_mismatch("full drop",
                                                           32'(resp_q[$].status),
                                                           32'(ST_FULL));

        // random symbol sequences across idling phases
        k = 0;
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            if (ph == 0) begin
                // long receiver hold-off while requests keep coming
                hold_off = 1'b1;
                fork
                    begin repeat (300) @(negedge i_clk); hold_off = 1'b0; end
                    for (int j = 0; j < 4; j++) send_request(CMD_PUSH, 8'($urandom), 0, 0, 0);
                join
            end
            while (k < (ph + 1) * N_RANDOM / 4) begin
                if ($urandom_range(9) == 0) begin
                    // noise: any command with any fields
                    send_request(t_cmd'($urandom_range(3)), 8'($urandom), $urandom,
                                 $urandom, $urandom);
                    k++;
                end else begin
                    // well formed symbol: top up, maybe restart, decode, update
                    while (m_count < 120 && $urandom_range(3) != 0) begin
                        send_request(CMD_PUSH, 8'($urandom), 0, 0, 0);
                        k++;
                    end
                    if ($urandom_range(15) == 0) begin
                        send_request(CMD_START, 0, 0, 0, 0);
                        k++;
                    end
                    tot = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 1000);
                    send_request(CMD_DECODE, 0, tot, 0, 0);
                    a = $urandom_range(tot - 1);
                    b = $urandom_range(tot, a + 1);
                    if ($urandom_range(7) == 0) b = $urandom;
                    send_request(CMD_UPDATE, 0, 0, a, b);
                    k += 2;
                end
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (resp_q.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
